// ===== rtl/vfdrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// vfdrtu_pkg: shared types and constants of the inverter link master
// Item and result structs, operation and status codes, function codes and
// the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package vfdrtu_pkg;

  // field widths
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_W         = 16;
  localparam int unsigned CFG_W          = 24;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned TIMER_BITS_DEF = 24;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT   = 1'd1;
  localparam logic [CFG_W-1:0]     FIRST_TIMEOUT_RST = 24'd1000;
  localparam logic [CFG_W-1:0]     GAP_TIMEOUT_RST   = 24'd100;

  // request function codes
  localparam logic [BYTE_W-1:0] FN_READ    = 8'h01;
  localparam logic [BYTE_W-1:0] FN_WRITE   = 8'h02;
  localparam logic [BYTE_W-1:0] FN_CONTROL = 8'h03;
  localparam logic [BYTE_W-1:0] FN_STATUS  = 8'h04;
  localparam logic [BYTE_W-1:0] FN_FREQ    = 8'h05;

  // length bytes placed in request frames
  localparam logic [BYTE_W-1:0] LEN_PARAM = 8'h03;
  localparam logic [BYTE_W-1:0] LEN_BYTE  = 8'h01;
  localparam logic [BYTE_W-1:0] LEN_WORD  = 8'h02;

  // expected reply lengths
  localparam logic [CNT_W-1:0] EXP_LONG  = 4'd8;
  localparam logic [CNT_W-1:0] EXP_SHORT = 4'd6;
  localparam logic [CNT_W-1:0] EXP_FREQ  = 4'd7;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC      = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_UNSUP    = 3'd4,
    ST_BUSY     = 3'd5
  } status_e;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_WAIT = 1'b1
  } phase_e;

  // one input transaction
  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] slave;
    logic [BYTE_W-1:0] fn;
    logic [BYTE_W-1:0] param;
    logic [WORD_W-1:0] data;
    logic [BYTE_W-1:0] rx;
  } in_item_t;

  // finished-transaction result from the controller
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] param;
    logic [WORD_W-1:0] data;
  } res_t;

  // request handed to the frame serializer
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] slave;
    logic [BYTE_W-1:0] fn;
    logic [BYTE_W-1:0] param;
    logic [WORD_W-1:0] data;
  } frame_req_t;

  // crc-16/modbus update by one byte, lsb first
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vfd_rtu_frame_master.sv =====
// A status result passes the input and result registers; the first frame byte
// also passes the frame serializer. Throughput: one transaction per cycle for
//   reply bytes and ticks while the result port accepts; a request blocks new
//   transactions until its whole frame is out, one byte per cycle when not stalled.
// Reset: asynchronous, active low; control state clears, timeouts return to
//   1000 and 100 ticks, the reply buffer is left as is. No clearing pass.
// ----------------------------------------------------------------------------
// vfd_rtu_frame_master: inverter link master, top level
// Input register, transaction controller, frame serializer and result
// register on stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_rtu_frame_master
  import vfdrtu_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // slave_address, function_code, parameter_number, data_value, rx_byte
  input  wire logic [47:0]          s_axis_tdata,
  // operation
  input  wire logic [1:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tx_byte, status, reply_length, reply_parameter, reply_data, 5 zero bits
  output logic [47:0]               m_axis_tdata,
  // kind
  output logic [0:0]                m_axis_tuser,
  output logic                      m_axis_tlast
);

  logic              in_valid_q;
  in_item_t          in_q;
  logic              out_free;
  logic              take;
  logic              tx_busy;
  logic [BYTE_W-1:0] tx_byte;
  logic              tx_last;
  res_t              res;
  frame_req_t        req;

  logic              m_valid_q;
  logic              m_kind_q;
  logic [BYTE_W-1:0] m_byte_q;
  logic              m_last_q;
  status_e           m_status_q;
  logic [BYTE_W-1:0] m_len_q;
  logic [BYTE_W-1:0] m_par_q;
  logic [WORD_W-1:0] m_data_q;

  // handshake
  assign out_free      = !m_valid_q || m_axis_tready;
  assign take          = in_valid_q && !tx_busy && out_free;
  assign s_axis_tready = !in_valid_q || take;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.op    <= s_axis_tuser;
      in_q.slave <= s_axis_tdata[7:0];
      in_q.fn    <= s_axis_tdata[15:8];
      in_q.param <= s_axis_tdata[23:16];
      in_q.data  <= s_axis_tdata[39:24];
      in_q.rx    <= s_axis_tdata[47:40];
    end
  end

  vfdrtu_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .item_i      (in_q),
    .res_o       (res),
    .req_o       (req)
  );

  vfdrtu_tx u_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .emit_i (out_free),
    .busy_o (tx_busy),
    .byte_o (tx_byte),
    .last_o (tx_last)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= tx_busy || res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (tx_busy) begin
        m_kind_q   <= 1'b0;
        m_byte_q   <= tx_byte;
        m_last_q   <= tx_last;
        m_status_q <= ST_OK;
        m_len_q    <= '0;
        m_par_q    <= '0;
        m_data_q   <= '0;
      end else begin
        m_kind_q   <= 1'b1;
        m_byte_q   <= '0;
        m_last_q   <= 1'b0;
        m_status_q <= res.status;
        m_len_q    <= res.len;
        m_par_q    <= res.param;
        m_data_q   <= res.data;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_data_q, m_par_q, m_len_q, m_status_q, m_byte_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // a finished-transaction result only comes from a taken transaction
  a_res_needs_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> take)
    else $error("controller result without a taken transaction");

  // a started request keeps the serializer busy next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |=> tx_busy)
    else $error("request started but serializer idle");

  // frame end marks only transmit bytes
  a_last_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 1'b0))
    else $error("last set on a status result");

  // nothing new is taken while a frame is being sent
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_busy |-> !res.valid && !req.start)
    else $error("transaction taken during frame transmit");
`endif

endmodule

`default_nettype wire

// ===== rtl/vfdrtu_tx.sv =====
// ----------------------------------------------------------------------------
// vfdrtu_tx: request frame serializer
// Builds the request bytes by function code and shifts them out one per cycle
// while emit_i is set, folding each into the CRC, then the CRC low byte first.
// ----------------------------------------------------------------------------
`default_nettype none

module vfdrtu_tx
  import vfdrtu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire frame_req_t        req_i,
  input  wire logic              emit_i,
  output logic                   busy_o,
  output logic [BYTE_W-1:0]      byte_o,
  output logic                   last_o
);

  localparam int unsigned NBYTES = 6;

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [BYTE_W-1:0] sh_q [NBYTES];
  logic [BYTE_W-1:0] sh_d [NBYTES];
  logic [WORD_W-1:0] crc_q, crc_d;

  assign busy_o = (rem_q != '0);
  assign last_o = (rem_q == CNT_W'(1));

  // frame byte, then crc low and high
  always_comb begin
    if (rem_q > CNT_W'(2)) begin
      byte_o = sh_q[0];
    end else if (rem_q == CNT_W'(2)) begin
      byte_o = crc_q[7:0];
    end else begin
      byte_o = crc_q[15:8];
    end
  end

  // load on request, shift on each emitted transaction
  always_comb begin
    rem_d = rem_q;
    crc_d = crc_q;
    for (int i = 0; i < NBYTES; i++) begin
      sh_d[i] = sh_q[i];
    end
    if (req_i.start) begin
      crc_d   = CRC_INIT;
      sh_d[0] = req_i.slave;
      sh_d[1] = req_i.fn;
      sh_d[4] = '0;
      sh_d[5] = '0;
      case (req_i.fn)
        FN_READ, FN_WRITE: begin
          sh_d[2] = LEN_PARAM;
          sh_d[3] = req_i.param;
          sh_d[4] = req_i.data[15:8];
          sh_d[5] = req_i.data[7:0];
          rem_d   = CNT_W'(8);
        end
        FN_CONTROL, FN_STATUS: begin
          sh_d[2] = LEN_BYTE;
          sh_d[3] = req_i.data[7:0];
          rem_d   = CNT_W'(6);
        end
        default: begin
          sh_d[2] = LEN_WORD;
          sh_d[3] = req_i.data[15:8];
          sh_d[4] = req_i.data[7:0];
          rem_d   = CNT_W'(7);
        end
      endcase
    end else if (busy_o && emit_i) begin
      rem_d = rem_q - CNT_W'(1);
      if (rem_q > CNT_W'(2)) begin
        crc_d = crc_byte(crc_q, sh_q[0]);
        for (int i = 0; i < NBYTES - 1; i++) begin
          sh_d[i] = sh_q[i+1];
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      crc_q <= CRC_INIT;
    end else begin
      rem_q <= rem_d;
      crc_q <= crc_d;
    end
  end

  // frame bytes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NBYTES; i++) begin
      sh_q[i] <= sh_d[i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vfdrtu_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfdrtu_ctrl: transaction controller
// Decodes each transaction, starts request frames, collects reply bytes with
// a running CRC, checks and extracts the reply, and times out idle lines.
// ----------------------------------------------------------------------------
`default_nettype none

module vfdrtu_ctrl
  import vfdrtu_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 take_i,
  input  wire in_item_t             item_i,
  output res_t                      res_o,
  output frame_req_t                req_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int unsigned BUF_LO = 1;
  localparam int unsigned BUF_HI = 5;

  logic [CFG_W-1:0]      first_to_q, gap_to_q;
  phase_e                phase_q, phase_d;
  logic [BYTE_W-1:0]     pend_fn_q, pend_fn_d;
  logic [CNT_W-1:0]      exp_q, exp_d;
  logic [CNT_W-1:0]      rcv_q, rcv_d;
  logic [WORD_W-1:0]     crc_q, crc_d;
  logic [TIMER_BITS-1:0] wait_q, wait_d;
  logic [BYTE_W-1:0]     buf_q [BUF_LO:BUF_HI];
  logic [BYTE_W-1:0]     prev1_q, prev2_q;
  logic                  byte_we;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_to_q <= FIRST_TIMEOUT_RST;
      gap_to_q   <= GAP_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIRST_TIMEOUT: first_to_q <= cfg_data_i;
        CFG_GAP_TIMEOUT:   gap_to_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode, collection, check and timeout
  always_comb begin
    logic [BYTE_W-1:0]     eff [BUF_LO:BUF_HI];
    logic [CNT_W-1:0]      cnt;
    logic [WORD_W-1:0]     crc_f;
    logic                  done;
    logic [CMP_W-1:0]      lim;
    logic [CMP_W-1:0]      mx;
    logic [TIMER_BITS-1:0] w_inc;

    phase_d   = phase_q;
    pend_fn_d = pend_fn_q;
    exp_d     = exp_q;
    rcv_d     = rcv_q;
    crc_d     = crc_q;
    wait_d    = wait_q;
    byte_we   = 1'b0;
    res_o     = '0;
    res_o.status = ST_OK;
    req_o       = '0;
    req_o.slave = item_i.slave;
    req_o.fn    = item_i.fn;
    req_o.param = item_i.param;
    req_o.data  = item_i.data;

    // reply buffer as seen with the current byte already written
    for (int i = BUF_LO; i <= BUF_HI; i++) begin
      eff[i] = (rcv_q == CNT_W'(i)) ? item_i.rx : buf_q[i];
    end
    cnt   = rcv_q + CNT_W'(1);
    crc_f = (rcv_q >= CNT_W'(2)) ? crc_byte(crc_q, prev2_q) : crc_q;
    done  = (cnt >= exp_q) ||
            ((cnt > CNT_W'(3)) && ({5'd0, cnt} == {1'b0, buf_q[2]} + 9'd5));
    mx    = CMP_W'({TIMER_BITS{1'b1}});
    lim   = (rcv_q == '0) ? CMP_W'(first_to_q) : CMP_W'(gap_to_q);
    if (lim > mx) begin
      lim = mx;
    end
    w_inc = (wait_q == {TIMER_BITS{1'b1}}) ? wait_q : wait_q + TIMER_BITS'(1);

    if (take_i) begin
      case (op_e'(item_i.op))
        OP_SEND: begin
          if (phase_q == PH_WAIT) begin
            res_o.valid  = 1'b1;
            res_o.status = ST_BUSY;
          end else if (item_i.fn >= FN_READ && item_i.fn <= FN_FREQ) begin
            req_o.start = 1'b1;
            phase_d     = PH_WAIT;
            pend_fn_d   = item_i.fn;
            rcv_d       = '0;
            wait_d      = '0;
            crc_d       = CRC_INIT;
            case (item_i.fn)
              FN_CONTROL: exp_d = EXP_SHORT;
              FN_FREQ:    exp_d = EXP_FREQ;
              default:    exp_d = EXP_LONG;
            endcase
          end else begin
            res_o.valid  = 1'b1;
            res_o.status = ST_UNSUP;
          end
        end
        OP_BYTE: begin
          if (phase_q == PH_WAIT) begin
            byte_we = 1'b1;
            rcv_d   = cnt;
            wait_d  = '0;
            crc_d   = crc_f;
            if (done) begin
              phase_d     = PH_IDLE;
              crc_d       = CRC_INIT;
              res_o.valid = 1'b1;
              if (prev1_q != crc_f[7:0] || item_i.rx != crc_f[15:8]) begin
                res_o.status = ST_CRC;
              end else if (eff[1] != pend_fn_q) begin
                res_o.status = ST_MISMATCH;
              end else begin
                res_o.len = eff[2];
                case (pend_fn_q)
                  FN_READ, FN_WRITE: begin
                    res_o.param = eff[3];
                    res_o.data  = (eff[2] == LEN_WORD) ? {8'h00, eff[4]} :
                                                         {eff[4], eff[5]};
                  end
                  FN_CONTROL: begin
                    res_o.param = '0;
                    res_o.data  = {8'h00, eff[3]};
                  end
                  FN_STATUS: begin
                    res_o.param = eff[3];
                    res_o.data  = {eff[4], eff[5]};
                  end
                  default: begin
                    res_o.param = eff[3];
                    res_o.data  = {eff[3], eff[4]};
                  end
                endcase
              end
            end
          end
        end
        OP_TICK: begin
          if (phase_q == PH_WAIT) begin
            wait_d = w_inc;
            if (CMP_W'(w_inc) >= lim) begin
              phase_d      = PH_IDLE;
              wait_d       = '0;
              crc_d        = CRC_INIT;
              res_o.valid  = 1'b1;
              res_o.status = ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pend_fn_q <= '0;
      exp_q     <= '0;
      rcv_q     <= '0;
      crc_q     <= CRC_INIT;
      wait_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      pend_fn_q <= pend_fn_d;
      exp_q     <= exp_d;
      rcv_q     <= rcv_d;
      crc_q     <= crc_d;
      wait_q    <= wait_d;
    end
  end

  // reply bytes: buffer entries read by extraction and the last two bytes
  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      for (int i = BUF_LO; i <= BUF_HI; i++) begin
        if (rcv_q[2:0] == 3'(i)) begin
          buf_q[i] <= item_i.rx;
        end
      end
      prev2_q <= prev1_q;
      prev1_q <= item_i.rx;
    end
  end

endmodule

`default_nettype wire
